// ===== hdl/fps_pkg.sv =====
package fps_pkg;

    localparam int FERMENTERS = 4;
    localparam int PROFILES   = 4;
    localparam int STEPS      = 15;
    localparam int ENTRIES    = PROFILES * STEPS;
    localparam int FER_W      = 2;
    localparam int POS_W      = 4;
    localparam int ADDR_W     = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        CMD_EVAL  = 3'd0,
        CMD_HOUR  = 3'd1,
        CMD_START = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_PAUSE = 3'd4,
        CMD_NEXT  = 3'd5,
        CMD_PREV  = 3'd6,
        CMD_WRITE = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [7:0]         days;
        logic signed [11:0] t_start;
        logic signed [11:0] t_end;
        logic [10:0]        trig;
    } step_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  fermenter;
        logic [2:0]  profile_number;
        logic [3:0]  step_index;
        logic [3:0]  step_type;
        logic [7:0]  step_days;
        logic signed [11:0] step_start_temp;
        logic signed [11:0] step_end_temp;
        logic [10:0] step_trigger;
        logic signed [11:0] control_temp;
        logic [10:0] gravity;
        logic [9:0]  attenuation;
    } in_word_t;

    typedef struct packed {
        logic signed [11:0] floor_temp;
        logic signed [11:0] ceiling_temp;
        logic [3:0]  active_step;
        logic        is_running;
        logic        step_advanced;
        logic        profile_finished;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_DIV, ST_LIMIT, ST_CHECK,
        ST_NXREAD, ST_NXWAIT, ST_CNT, ST_CNTWAIT, ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic signed [12:0] num_mag_sign;
        logic [16:0] hours;
        logic [12:0] span;
    } div_req_t;

    function automatic logic is_empty(input step_t s);
        return s.kind == 4'd0 && s.days == 8'd0 && s.t_start == 12'sd0
               && s.t_end == 12'sd0;
    endfunction

    function automatic logic signed [11:0] sat12(input logic signed [13:0] v);
        if (v < -14'sd2048) return -12'sd2048;
        if (v > 14'sd2047) return 12'sd2047;
        return v[11:0];
    endfunction

    function automatic logic temp_near(input logic signed [11:0] t,
                                       input logic signed [11:0] tg);
        logic signed [12:0] d;
        d = 13'(t) - 13'(tg);
        return (t >= -12'sd1600) && d <= 13'sd8 && d >= -13'sd8;
    endfunction

endpackage

// ===== hdl/fps_if.sv =====
interface fps_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fps_ramp.sv =====
// shift-subtract unit: product (diff * hours) / span, one quotient bit per cycle
module fps_ramp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [12:0] diff,
    input  logic [12:0]        hours,
    input  logic [12:0]        span,
    output logic               done,
    output logic signed [12:0] quot
);
    import fps_pkg::*;

    logic [25:0] rem_reg, rem_next;
    logic [25:0] q_reg, q_next;
    logic [12:0] span_reg, span_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [12:0] mag;
    logic [26:0] trial;

    always_comb
    begin
        mag = diff[12] ? 13'(-diff) : 13'(diff);
        busy_next = busy_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        span_next = span_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        done = 1'b0;
        trial = {rem_reg, q_reg[25]} - 27'(span_reg);
        if (start)
        begin
            busy_next = 1'b1;
            q_next = mag * hours;
            rem_next = '0;
            span_next = span;
            neg_next = diff[12];
            cnt_next = 5'd0;
        end
        else if (busy_reg)
        begin
            if (!trial[26])
                rem_next = trial[25:0];
            else
                rem_next = {rem_reg[24:0], q_reg[25]};
            q_next = {q_reg[24:0], ~trial[26]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd25)
                busy_next = 1'b0;
        end
        else
            done = cnt_reg == 5'd26;
        quot = neg_reg ? -13'(q_reg) : 13'(q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= done ? 5'd0 : cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        span_reg <= span_next;
        neg_reg  <= neg_next;
    end
endmodule

// ===== hdl/fermentation_profile_sequencer.sv =====
// Profile sequencer for four fermenters. Each word is taken, worked and answered
// with one result word; ready is low from acceptance until the result is taken.
// The step table is a 60-entry memory cleared by a pass over all entries after reset,
// during which no word is taken. Write, tick, start, stop, pause, prev and any idle
// command go from ST_READ straight to ST_OUT. Evaluate reads the step in ST_WAIT and
// answers at once on an empty step; a flat step passes ST_LIMIT and ST_CHECK, and a
// ramp step first waits in ST_DIV for the bit-serial ramp divider; ST_NXREAD and
// ST_NXWAIT follow when it advances, to read the following step. Next reads the table
// once per step in ST_CNT and ST_CNTWAIT while the leading non-empty steps are counted.
module fermentation_profile_sequencer (
    input  logic clk,
    input  logic rst_n,
    fps_if.sink   in_ch,
    fps_if.source out_ch
);
    import fps_pkg::*;

    step_t mem [ENTRIES];
    step_t rd_reg;
    logic [ADDR_W-1:0] raddr, waddr_reg, waddr_next;
    logic [ADDR_W-1:0] wa;
    logic mwe;
    step_t mwd;

    state_t state_reg, state_next;
    in_word_t in_reg, in_next;
    out_word_t res_reg, res_next;

    logic [2:0]  prof_reg [FERMENTERS], prof_next [FERMENTERS];
    logic [3:0]  pos_reg [FERMENTERS], pos_next [FERMENTERS];
    logic [15:0] hrs_reg [FERMENTERS], hrs_next [FERMENTERS];
    logic        run_reg [FERMENTERS], run_next [FERMENTERS];
    logic signed [11:0] flo_reg [FERMENTERS], flo_next [FERMENTERS];
    logic signed [11:0] cei_reg [FERMENTERS], cei_next [FERMENTERS];

    logic [3:0] cnt_reg, cnt_next;
    logic signed [12:0] tgt_reg, tgt_next;
    logic adv_reg, adv_next, fin_reg, fin_next;

    logic div_start, div_done;
    logic signed [12:0] div_q;
    logic [12:0] span, hclip;
    logic [FER_W-1:0] f;
    logic [2:0] p;
    logic timed, sg_ok, att_ok, done_c, nx_empty;

    fps_ramp u_ramp (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .diff(13'(rd_reg.t_end) - 13'(rd_reg.t_start)),
        .hours(hclip), .span(span), .done(div_done), .quot(div_q)
    );

    always_ff @(posedge clk)
    begin
        if (mwe)
            mem[wa] <= mwd;
        rd_reg <= mem[raddr];
    end

    assign f = in_reg.fermenter;
    assign p = prof_reg[f];
    assign span = 13'(rd_reg.days) * 13'd24;
    assign hclip = (17'(hrs_reg[f]) > 17'(span)) ? span : hrs_reg[f][12:0];
    assign timed = 17'(hrs_reg[f]) >= 17'(span);
    assign sg_ok = in_reg.gravity > 11'd500 && in_reg.gravity <= rd_reg.trig;
    assign att_ok = 11'(in_reg.attenuation) >= rd_reg.trig;
    assign nx_empty = is_empty(rd_reg);

    always_comb
    begin
        unique case (rd_reg.kind)
            4'd0: done_c = timed && temp_near(in_reg.control_temp, rd_reg.t_end);
            4'd3, 4'd6: done_c = sg_ok;
            4'd4, 4'd7: done_c = att_ok;
            4'd5: done_c = temp_near(in_reg.control_temp, rd_reg.t_end);
            4'd8: done_c = timed && sg_ok;
            4'd9: done_c = timed && att_ok;
            default: done_c = timed;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        in_next = in_reg;
        res_next = res_reg;
        prof_next = prof_reg;
        pos_next = pos_reg;
        hrs_next = hrs_reg;
        run_next = run_reg;
        flo_next = flo_reg;
        cei_next = cei_reg;
        cnt_next = cnt_reg;
        tgt_next = tgt_reg;
        adv_next = adv_reg;
        fin_next = fin_reg;
        waddr_next = waddr_reg;
        mwe = 1'b0;
        mwd = '0;
        div_start = 1'b0;
        raddr = ADDR_W'((p - 3'd1) * STEPS) + ADDR_W'(pos_reg[f]);
        in_ch.ready = state_reg == ST_IDLE;
        out_ch.valid = state_reg == ST_OUT;
        out_ch.data = res_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mwe = 1'b1;
                waddr_next = waddr_reg + ADDR_W'(1);
                if (waddr_reg == ADDR_W'(ENTRIES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    in_next = in_ch.data;
                    adv_next = 1'b0;
                    fin_next = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LIMIT;
                if (in_reg.command == CMD_WRITE && in_reg.profile_number >= 3'd1
                    && in_reg.profile_number <= 3'(PROFILES)
                    && in_reg.step_index < 4'(STEPS))
                    mwe = 1'b1;
                unique case (cmd_t'(in_reg.command))
                    CMD_EVAL:
                        if (p != 3'd0 && run_reg[f])
                            state_next = ST_WAIT;
                    CMD_HOUR:
                        if (run_reg[f] && hrs_reg[f] != 16'hFFFF)
                            hrs_next[f] = hrs_reg[f] + 16'd1;
                    CMD_START:
                        if (in_reg.profile_number >= 3'd1
                            && in_reg.profile_number <= 3'(PROFILES))
                        begin
                            prof_next[f] = in_reg.profile_number;
                            pos_next[f] = '0;
                            hrs_next[f] = '0;
                            run_next[f] = 1'b1;
                        end
                    CMD_STOP:
                    begin
                        run_next[f] = 1'b0;
                        prof_next[f] = '0;
                        pos_next[f] = '0;
                        hrs_next[f] = '0;
                    end
                    CMD_PAUSE: run_next[f] = 1'b0;
                    CMD_NEXT:
                        if (p != 3'd0 && run_reg[f])
                        begin
                            cnt_next = '0;
                            state_next = ST_CNT;
                        end
                    CMD_PREV:
                        if (p != 3'd0 && run_reg[f] && pos_reg[f] != 4'd0)
                        begin
                            pos_next[f] = pos_reg[f] - 4'd1;
                            hrs_next[f] = '0;
                            adv_next = 1'b1;
                        end
                    default: ;
                endcase
                if (state_next == ST_LIMIT)
                    state_next = ST_OUT;
            end
            ST_WAIT:
            begin
                // table word now in rd_reg
                if (pos_reg[f] >= 4'(STEPS) || nx_empty)
                begin
                    run_next[f] = 1'b0;
                    fin_next = 1'b1;
                    state_next = ST_OUT;
                end
                else if (rd_reg.days != 8'd0 && rd_reg.t_start != rd_reg.t_end)
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    tgt_next = 13'(rd_reg.t_end);
                    state_next = ST_LIMIT;
                end
            end
            ST_DIV:
                if (div_done)
                begin
                    tgt_next = 13'(rd_reg.t_start) + div_q;
                    state_next = ST_LIMIT;
                end
            ST_LIMIT:
            begin
                if (tgt_reg > -13'sd1600)
                begin
                    flo_next[f] = sat12(14'(tgt_reg) - 14'sd8);
                    cei_next[f] = sat12(14'(tgt_reg) + 14'sd8);
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_OUT;
                if (done_c)
                begin
                    pos_next[f] = pos_reg[f] + 4'd1;
                    hrs_next[f] = '0;
                    adv_next = 1'b1;
                    if (pos_reg[f] + 4'd1 >= 4'(STEPS))
                    begin
                        run_next[f] = 1'b0;
                        fin_next = 1'b1;
                    end
                    else
                        state_next = ST_NXREAD;
                end
            end
            ST_NXREAD: state_next = ST_NXWAIT;
            ST_NXWAIT:
            begin
                if (nx_empty)
                begin
                    run_next[f] = 1'b0;
                    fin_next = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_CNT:
            begin
                raddr = ADDR_W'((p - 3'd1) * STEPS) + ADDR_W'(cnt_reg);
                state_next = ST_CNTWAIT;
            end
            ST_CNTWAIT:
            begin
                // count leading non-empty steps until the one past the current
                if (nx_empty || cnt_reg > pos_reg[f])
                begin
                    if (nx_empty && cnt_reg <= pos_reg[f] + 4'd1
                        || cnt_reg == pos_reg[f] + 4'd1 && nx_empty)
                    begin
                        run_next[f] = 1'b0;
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        pos_next[f] = pos_reg[f] + 4'd1;
                        hrs_next[f] = '0;
                        adv_next = 1'b1;
                    end
                    state_next = ST_OUT;
                end
                else if (cnt_reg == 4'(STEPS - 1))
                begin
                    run_next[f] = 1'b0;
                    fin_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                    state_next = ST_CNT;
                end
            end
            ST_OUT:
                if (out_ch.ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_READ)
        begin
            mwd.kind = in_reg.step_type;
            mwd.days = in_reg.step_days;
            mwd.t_start = in_reg.step_start_temp;
            mwd.t_end = in_reg.step_end_temp;
            mwd.trig = in_reg.step_trigger;
        end
        if (state_reg == ST_NXREAD)
            raddr = ADDR_W'((p - 3'd1) * STEPS) + ADDR_W'(pos_reg[f]);
        res_next.floor_temp = flo_next[f];
        res_next.ceiling_temp = cei_next[f];
        res_next.active_step = pos_next[f];
        res_next.is_running = run_next[f];
        res_next.step_advanced = adv_next;
        res_next.profile_finished = fin_next;
    end

    assign wa = (state_reg == ST_CLEAR) ? waddr_reg
              : ADDR_W'((in_reg.profile_number - 3'd1) * STEPS)
                + ADDR_W'(in_reg.step_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            waddr_reg <= '0;
            for (int i = 0; i < FERMENTERS; i++)
            begin
                prof_reg[i] <= '0;
                pos_reg[i] <= '0;
                hrs_reg[i] <= '0;
                run_reg[i] <= 1'b0;
                flo_reg[i] <= '0;
                cei_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            waddr_reg <= waddr_next;
            prof_reg <= prof_next;
            pos_reg <= pos_next;
            hrs_reg <= hrs_next;
            run_reg <= run_next;
            flo_reg <= flo_next;
            cei_reg <= cei_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
        cnt_reg <= cnt_next;
        tgt_reg <= tgt_next;
        adv_reg <= adv_next;
        fin_reg <= fin_next;
        if (state_reg != ST_OUT)
            res_reg <= res_next;
    end
endmodule

// ===== hdl/fps_checker.sv =====
module fps_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input fps_pkg::out_word_t out_data
);
    import fps_pkg::*;

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after word taken");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.profile_finished |-> !out_data.is_running)
        else $error("finished but running");
    a_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.floor_temp <= out_data.ceiling_temp)
        else $error("floor above ceiling");
endmodule

bind fermentation_profile_sequencer fps_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
